[rtl/tccw_pkg.sv]
`default_nettype none

package tccw_pkg;

    // Operation codes on func
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Control bytes handled by a put
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Printable range and blank cell contents
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7F;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'd240;

    // Fixed field widths
    localparam int CELL_W = 16;
    localparam int POS_W  = 11;

    // What a put step asks of the cell store
    typedef struct packed {
        logic wr_char;   // store ch at the old cursor cell
        logic scroll;    // cursor ran off the last row
    } put_info_t;

endpackage

`default_nettype wire

[rtl/text_console_char_writer_unit.sv]
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  func, ch, read_row, read_col
// out       output     out_valid / out_stall cursor_pos, cell_char, cell_attr, scrolled
// cfg       input      cfg_valid / cfg_ready cfg_data (cell attribute)
//
// Put without scroll, read off screen, unused func: S_EXEC, then S_DONE; a read of a screen
// cell passes S_READ between the two. A scroll copies (ROWS-1)*COLUMNS cells by read and
// write back, then blanks the last row; clear blanks all ROWS*COLUMNS cells.
// Both are bound by the single write port.
// After reset the store is blanked one cell a cycle, with in_stall high; cfg writes
// are taken throughout. A new word is taken while a result waits in the output register.
`default_nettype none

module text_console_char_writer_unit
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  ch,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] cursor_pos,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_attr,
    output logic        scrolled,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic          pend_reg;
    logic          pend_next;
    logic [AW-1:0] dst_reg;
    logic [AW-1:0] dst_next;
    logic [7:0]    attr_reg;

    // Latched input word
    logic [1:0]    func_reg;
    logic [7:0]    ch_reg;
    logic [4:0]    rrow_reg;
    logic [6:0]    rcol_reg;

    // Result being built
    logic [7:0]    rd_char_reg;
    logic [7:0]    rd_char_next;
    logic [7:0]    rd_attr_reg;
    logic [7:0]    rd_attr_next;
    logic          scroll_reg;
    logic          scroll_next;

    // Output register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [10:0]   out_pos_reg;
    logic [7:0]    out_char_reg;
    logic [7:0]    out_attr_reg;
    logic          out_scroll_reg;
    logic          out_load;

    // Cell store ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;

    // Cursor
    logic                 cur_step;
    logic                 cur_clear;
    logic [RW-1:0]        cur_row;
    logic [CW-1:0]        cur_col;
    put_info_t            put_info;
    logic [AW-1:0]        cur_addr;
    logic [AW-1:0]        rd_addr;
    logic [PW-1:0]        pos_ext;
    logic                 rd_in_range;
    logic                 move_more;

    tccw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tccw_cursor #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (cur_step),
        .clear  (cur_clear),
        .ch     (ch_reg),
        .cur_row(cur_row),
        .cur_col(cur_col),
        .info   (put_info)
    );

    // Linear cell addresses
    assign cur_addr    = AW'(32'(cur_row) * COLUMNS + 32'(cur_col));
    assign rd_addr     = AW'(32'(rrow_reg) * COLUMNS + 32'(rcol_reg));
    assign rd_in_range = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);
    assign pos_ext     = PW'(cur_addr);
    assign move_more   = (cnt_reg != AW'(MOVE_COUNT));

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        dst_next     = dst_reg;
        rd_char_next = rd_char_reg;
        rd_attr_next = rd_attr_reg;
        scroll_next  = scroll_reg;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg;
        ram_wdata    = {attr_reg, BLANK_CHAR};
        ram_re       = 1'b0;
        ram_raddr    = rd_addr;
        cur_step     = 1'b0;
        cur_clear    = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {RESET_ATTR, BLANK_CHAR};
                if (cnt_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = S_EXEC;
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    scroll_next  = 1'b0;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    FUNC_PUT:
                    begin
                        cur_step  = 1'b1;
                        ram_we    = put_info.wr_char;
                        ram_waddr = cur_addr;
                        ram_wdata = {attr_reg, ch_reg};
                        if (put_info.scroll)
                        begin
                            scroll_next = 1'b1;
                            cnt_next    = '0;
                            state_next  = S_SCROLL;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FUNC_READ:
                    begin
                        if (rd_in_range)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cur_clear  = 1'b1;
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                rd_char_next = ram_rdata[7:0];
                rd_attr_next = ram_rdata[15:8];
                state_next   = S_DONE;
            end
            S_SCROLL:
            begin
                // read one row down, write it back in the next cycle
                if (move_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(32'(cnt_reg) + COLUMNS);
                    pend_next = 1'b1;
                    dst_next  = cnt_reg;
                    cnt_next  = cnt_reg + AW'(1);
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (!move_more && !pend_reg)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            attr_reg      <= RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        dst_reg     <= dst_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
        scroll_reg  <= scroll_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            ch_reg   <= ch;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (out_load)
        begin
            out_pos_reg    <= pos_ext[POS_W-1:0];
            out_char_reg   <= rd_char_reg;
            out_attr_reg   <= rd_attr_reg;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = out_pos_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign scrolled   = out_scroll_reg;

endmodule

`default_nettype wire

[rtl/tccw_ram.sv]
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/tccw_cursor.sv]
`default_nettype none

module tccw_cursor
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    localparam int CW = $clog2(COLUMNS),
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          clear,
    input  logic [7:0]    ch,
    output logic [RW-1:0] cur_row,
    output logic [CW-1:0] cur_col,
    output put_info_t     info
);

    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;

    // One spare bit each: a tab can run up to 8 past the last column,
    // and a wrap can run one row past the last
    logic [CW:0] col_step;
    logic [RW:0] row_step;
    logic [CW:0] col_wrap;
    logic [RW:0] row_wrap;
    logic        printable;
    logic        off_bottom;

    // Effect of the byte on the cursor
    always_comb
    begin
        col_step  = {1'b0, col_reg};
        row_step  = {1'b0, row_reg};
        printable = 1'b0;
        case (ch)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_step = {1'b0, col_reg} - (CW+1)'(1);
                end
            end
            CH_CR:
            begin
                col_step = '0;
            end
            CH_LF:
            begin
                col_step = '0;
                row_step = {1'b0, row_reg} + (RW+1)'(1);
            end
            CH_TAB:
            begin
                col_step = ({1'b0, col_reg} | (CW+1)'(7)) + (CW+1)'(1);
            end
            default:
            begin
                if (ch inside {[PRINT_LO:PRINT_HI]})
                begin
                    printable = 1'b1;
                    col_step  = {1'b0, col_reg} + (CW+1)'(1);
                end
            end
        endcase
    end

    // Wrap past the last column, then clamp to the last row
    always_comb
    begin
        col_wrap = col_step;
        row_wrap = row_step;
        if (col_step >= (CW+1)'(COLUMNS))
        begin
            col_wrap = col_step - (CW+1)'(COLUMNS);
            row_wrap = row_step + (RW+1)'(1);
        end
        off_bottom = (row_wrap >= (RW+1)'(ROWS));
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (clear)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (step)
        begin
            col_next = col_wrap[CW-1:0];
            row_next = off_bottom ? RW'(ROWS - 1) : row_wrap[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign cur_row      = row_reg;
    assign cur_col      = col_reg;
    assign info.wr_char = step && printable;
    assign info.scroll  = step && off_bottom;

endmodule

`default_nettype wire

[rtl/tccw_checker.sv]
`default_nettype none

module tccw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [10:0] cursor_pos,
    input wire [7:0]  cell_char,
    input wire [7:0]  cell_attr,
    input wire        scrolled
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
    localparam bit POS_EXACT = (CELL_COUNT <= 2048);

    // A held result keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_pos)
            && $stable(cell_char) && $stable(cell_attr) && $stable(scrolled))
        else $error("output word changed while stalled");

    // One word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken before the first finished");

    // Cursor always lands on a screen cell
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !POS_EXACT || (32'(cursor_pos) < CELL_COUNT))
        else $error("cursor off screen");

    // A scroll leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> !POS_EXACT || (32'(cursor_pos) >= MOVE_COUNT))
        else $error("scroll without cursor on last row");

    // Only a read returns cell contents, and a read never scrolls
    a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cell_char == 8'd0) && (cell_attr == 8'd0))
        else $error("scroll word carries cell data");

endmodule

bind text_console_char_writer_unit tccw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
) u_tccw_checker (.*);

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

module testbench;
    import tccw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS_N = 25;
    localparam int CELL_TOTAL = COLS * ROWS_N;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WORDS_PER_PHASE = 280;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [7:0]  ch;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // when set, neither side inserts gaps or stalls
    bit quiet = 1'b0;

    // one result word as the block reports it
    typedef struct packed {
        logic [10:0] pos;
        logic [7:0]  chr;
        logic [7:0]  attr;
        logic        scroll;
    } cell_report_t;

    // Tracks screen, cursor and attribute; predicts one report per accepted word
    class screen_scoreboard;
        logic [15:0]  cells [CELL_TOTAL];
        int unsigned  cur_col;
        int unsigned  cur_row;
        logic [7:0]   attr;
        cell_report_t reports_q [$];
        int unsigned  fails;

        function new();
            attr = RESET_ATTR;
            blank(0, CELL_TOTAL);
            cur_col = 0;
            cur_row = 0;
            fails = 0;
        endfunction

        function void blank(int first, int count);
            for (int i = 0; i < count; i++)
                cells[first + i] = {attr, BLANK_CHAR};
        endfunction

        function void set_attr(logic [7:0] a);
            attr = a;
        endfunction

        function int pending();
            return reports_q.size();
        endfunction

        // fold column overflow into rows, scroll once off the bottom
        function bit settle_cursor();
            if (cur_col >= COLS)
            begin
                cur_row += cur_col / COLS;
                cur_col = cur_col % COLS;
            end
            if (cur_row >= ROWS_N)
            begin
                for (int i = 0; i < (ROWS_N - 1) * COLS; i++)
                    cells[i] = cells[i + COLS];
                blank((ROWS_N - 1) * COLS, COLS);
                cur_row = ROWS_N - 1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit put_byte(logic [7:0] c);
            case (c)
                CH_BS:  if (cur_col > 0) cur_col -= 1;
                CH_CR:  cur_col = 0;
                CH_LF:
                begin
                    cur_row += 1;
                    cur_col = 0;
                end
                CH_TAB: cur_col += 8 - (cur_col % 8);
                default:
                begin
                    if (c >= PRINT_LO && c <= PRINT_HI)
                    begin
                        cells[cur_row * COLS + cur_col] = {attr, c};
                        cur_col += 1;
                    end
                end
            endcase
            return settle_cursor();
        endfunction

        function void note_word(logic [1:0] f, logic [7:0] c, logic [4:0] r, logic [6:0] k);
            cell_report_t rep;
            rep = '0;
            case (f)
                FUNC_PUT: rep.scroll = put_byte(c);
                FUNC_READ:
                begin
                    if (r < ROWS_N && k < COLS)
                        {rep.attr, rep.chr} = cells[r * COLS + k];
                end
                FUNC_CLEAR:
                begin
                    blank(0, CELL_TOTAL);
                    cur_col = 0;
                    cur_row = 0;
                end
                default: ;
            endcase
            rep.pos = 11'(cur_row * COLS + cur_col);
            reports_q.push_back(rep);
        endfunction

        function void check_result(logic [10:0] pos, logic [7:0] chr, logic [7:0] at,
                                   logic scr);
            cell_report_t want;
            if (reports_q.size() == 0)
            begin
                $error("result word with nothing expected, cursor_pos %0d", pos);
                fails++;
                return;
            end
            want = reports_q.pop_front();
            if (pos !== want.pos)
            begin
                $error("cursor_pos: expected %0d, got %0d", want.pos, pos);
                fails++;
            end
            if (chr !== want.chr)
            begin
                $error("cell_char: expected 0x%02h, got 0x%02h", want.chr, chr);
                fails++;
            end
            if (at !== want.attr)
            begin
                $error("cell_attr: expected 0x%02h, got 0x%02h", want.attr, at);
                fails++;
            end
            if (scr !== want.scroll)
            begin
                $error("scrolled: expected %0b, got %0b", want.scroll, scr);
                fails++;
            end
        endfunction
    endclass

    screen_scoreboard sb;

    text_console_char_writer_unit #(
        .COLUMNS(COLS),
        .ROWS(ROWS_N)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .ch(ch),
        .read_row(read_row),
        .read_col(read_col),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cursor_pos(cursor_pos),
        .cell_char(cell_char),
        .cell_attr(cell_attr),
        .scrolled(scrolled),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 18);
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(cursor_pos, cell_char, cell_attr, scrolled);
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic [1:0] f, logic [7:0] c, logic [4:0] r, logic [6:0] k);
        while (!quiet && ($urandom_range(99) < 18))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        ch       <= c;
        read_row <= r;
        read_col <= k;
        do @(posedge clk); while (in_stall);
        sb.note_word(f, c, r, k);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_attr(logic [7:0] a);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        sb.set_attr(a);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly text with controls, reads near the cursor, rare clears
    task automatic send_random_word();
        int unsigned pick;
        int unsigned roll;
        int unsigned back;
        logic [7:0]  c;
        logic [4:0]  r;
        logic [6:0]  k;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        c = 8'($urandom);
        r = 5'($urandom);
        k = 7'($urandom);
        if (pick < 64)
        begin
            if (roll < 72)      c = 8'($urandom_range(32, 127));
            else if (roll < 78) c = CH_LF;
            else if (roll < 82) c = CH_CR;
            else if (roll < 87) c = CH_BS;
            else if (roll < 92) c = CH_TAB;
            else if (roll < 96) c = 8'($urandom_range(0, 31));
            else                c = 8'($urandom_range(128, 255));
            send_word(FUNC_PUT, c, r, k);
        end
        else if (pick < 91)
        begin
            if (roll < 60)
            begin
                back = $urandom_range(0, 2);
                if (back > sb.cur_row) back = sb.cur_row;
                r = 5'(sb.cur_row - back);
                k = 7'($urandom_range(0, COLS - 1));
            end
            else if (roll < 85)
            begin
                r = 5'($urandom_range(0, ROWS_N - 1));
                k = 7'($urandom_range(0, COLS - 1));
            end
            send_word(FUNC_READ, c, r, k);
        end
        else if (pick < 93)
        begin
            send_word(FUNC_CLEAR, c, r, k);
        end
        else
        begin
            send_word(FUNC_UNUSED, c, r, k);
        end
    endtask

    initial
    begin
        logic [7:0] phase_attr [6];
        sb = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_PUT;
        ch        = '0;
        read_row  = '0;
        read_col  = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset contents, corners and out-of-range reads
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'hFF, 5'(ROWS_N - 1), 7'(COLS - 1));
        send_word(FUNC_READ, 8'h00, 5'(ROWS_N), 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd31, 7'd127);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'(COLS));
        // printable extremes and ignored bytes
        send_word(FUNC_PUT, 8'h41, 5'd31, 7'd127);
        send_word(FUNC_PUT, PRINT_HI, 5'd0, 7'd0);
        send_word(FUNC_PUT, PRINT_LO, 5'd0, 7'd0);
        send_word(FUNC_PUT, 8'h1F, 5'd0, 7'd0);
        send_word(FUNC_PUT, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_PUT, 8'h80, 5'd0, 7'd0);
        send_word(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
        // cursor controls, backspace held at column zero
        send_word(FUNC_PUT, CH_BS, 5'd0, 7'd0);
        send_word(FUNC_PUT, CH_CR, 5'd0, 7'd0);
        send_word(FUNC_PUT, CH_BS, 5'd0, 7'd0);
        send_word(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
        send_word(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd1);
        send_word(FUNC_UNUSED, 8'hAA, 5'd21, 7'd85);
        send_word(FUNC_PUT, CH_LF, 5'd0, 7'd0);
        send_word(FUNC_CLEAR, 8'h55, 5'd10, 7'd42);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);

        // scrolling: line feed off the last row, then tab and text wrapping off it
        send_word(FUNC_PUT, 8'h41, 5'd0, 7'd0);
        send_word(FUNC_PUT, CH_LF, 5'd0, 7'd0);
        send_word(FUNC_PUT, 8'h42, 5'd0, 7'd0);
        for (int i = 0; i < ROWS_N - 1; i++)
            send_word(FUNC_PUT, CH_LF, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);
        for (int i = 0; i < COLS / 8; i++)
            send_word(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
        for (int i = 0; i <= COLS; i++)
            send_word(FUNC_PUT, 8'(int'(PRINT_LO) + i), 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'(ROWS_N - 2), 7'(COLS - 1));
        send_word(FUNC_READ, 8'h00, 5'(ROWS_N - 1), 7'd0);
        send_word(FUNC_READ, 8'h00, 5'(ROWS_N - 1), 7'd1);
        drain();

        // random phases, attribute changed while idle; one phase without gaps
        phase_attr = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, 8'($urandom), 8'hA5};
        for (int p = 0; p < 6; p++)
        begin
            write_attr(phase_attr[p]);
            quiet = (p == 3);
            repeat (WORDS_PER_PHASE) send_random_word();
            drain();
        end
        quiet = 1'b0;

        repeat (20) @(posedge clk);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
